/* sv/sbc_pkg.sv */
// shared types and constants of the swept box collision block
package sbc_pkg;

   // pipeline control handed from the top level to its arithmetic units
   typedef struct packed {
      logic adv;
   } pipe_ctl_type;

   // contact normal codes, two bits signed
   localparam logic [1:0] NORM_ZERO = 2'b00;
   localparam logic [1:0] NORM_POS  = 2'b01;
   localparam logic [1:0] NORM_NEG  = 2'b11;

endpackage

/* sv/sbc_div.sv */
// pipelined restoring divider: saturated signed num * 2^frac / den, one quotient bit a stage
module sbc_div #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 40,
   parameter int QUO_W  = 32,
   parameter int FRAC_W = 16
) (
   input  logic                      clock,
   input  sbc_pkg::pipe_ctl_type     ctl,
   input  logic signed [NUM_W-1:0]   num,
   input  logic signed [DEN_W-1:0]   den,
   output logic signed [QUO_W-1:0]   quo
);

   localparam int NX_W  = NUM_W + FRAC_W;
   localparam int R0_W  = NX_W - QUO_W;
   localparam int CMP_W = (R0_W > DEN_W) ? R0_W : DEN_W;

   typedef struct packed {
      logic neg;
      logic ovf;
      logic den_zero;
      logic num_pos;
   } flag_type;

   logic [NUM_W-1:0] num_mag;
   logic [DEN_W-1:0] den_mag;
   logic [NX_W-1:0]  num_sh;
   logic [R0_W-1:0]  rem0;
   flag_type         flag_in;

   logic [DEN_W-1:0] rem_ff  [0:QUO_W];
   logic [DEN_W-1:0] dvs_ff  [0:QUO_W];
   logic [QUO_W-1:0] low_ff  [0:QUO_W];
   logic [QUO_W-1:0] q_ff    [0:QUO_W];
   flag_type         flag_ff [0:QUO_W];

   logic [QUO_W-1:0] pos_lim;
   logic [QUO_W-1:0] neg_lim;
   logic [QUO_W-1:0] lim;
   logic [QUO_W-1:0] q_sat;
   logic [QUO_W-1:0] quo_in;
   logic [QUO_W-1:0] quo_ff;

   // magnitudes and the overflow check on the top partial remainder
   assign num_mag = num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
   assign den_mag = den[DEN_W-1] ? unsigned'(-den) : unsigned'(den);
   assign num_sh  = {num_mag, {FRAC_W{1'b0}}};
   assign rem0    = num_sh[NX_W-1:QUO_W];

   always_comb begin
      flag_in.neg      = num[NUM_W-1] ^ den[DEN_W-1];
      flag_in.ovf      = CMP_W'(rem0) >= CMP_W'(den_mag);
      flag_in.den_zero = (den == '0);
      flag_in.num_pos  = ~num[NUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         rem_ff[0]  <= DEN_W'(rem0);
         dvs_ff[0]  <= den_mag;
         low_ff[0]  <= num_sh[QUO_W-1:0];
         q_ff[0]    <= '0;
         flag_ff[0] <= flag_in;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;

      assign trial = {rem_ff[k-1], low_ff[k-1][QUO_W-k]};
      assign diff  = trial - {1'b0, dvs_ff[k-1]};

      always_ff @(posedge clock) begin
         if (ctl.adv) begin
            if (trial >= {1'b0, dvs_ff[k-1]}) begin
               rem_ff[k] <= diff[DEN_W-1:0];
               q_ff[k]   <= {q_ff[k-1][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= trial[DEN_W-1:0];
               q_ff[k]   <= {q_ff[k-1][QUO_W-2:0], 1'b0};
            end
            dvs_ff[k]  <= dvs_ff[k-1];
            low_ff[k]  <= low_ff[k-1];
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   // saturate, apply the sign, and handle a zero divisor
   assign pos_lim = {1'b0, {(QUO_W-1){1'b1}}};
   assign neg_lim = {1'b1, {(QUO_W-1){1'b0}}};
   assign lim     = flag_ff[QUO_W].neg ? neg_lim : pos_lim;
   assign q_sat   = (flag_ff[QUO_W].ovf || (q_ff[QUO_W] > lim)) ? lim : q_ff[QUO_W];

   always_comb begin
      if (flag_ff[QUO_W].den_zero) begin
         quo_in = flag_ff[QUO_W].num_pos ? pos_lim : neg_lim;
      end else if (flag_ff[QUO_W].neg) begin
         quo_in = -q_sat;
      end else begin
         quo_in = q_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = signed'(quo_ff);

endmodule

/* sv/swept_box_collision.sv */
// top level of the swept box collision pipeline
// a request moves through stage a, the dividers, stages c to f and the response register
// throughput: one transaction per cycle if not stalled; the four slab dividers take one quotient bit a stage
// the whole pipeline advances together whenever the response register is empty or drained
// reset clears every valid bit; payload registers are not reset
// no state is kept between transactions
module swept_box_collision #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // mover_x, mover_y, mover_w, mover_h, target_x, target_y, target_w, target_h,
   // vel_x, vel_y, step_time, zero fill
   input  logic [((10*COORD_BITS+FRAC_BITS+4+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, contact_time, contact_x, contact_y, normal_x, normal_y, zero fill
   output logic [((3*COORD_BITS+5+7)/8)*8-1:0] rsp_tdata
);

   localparam int CB        = COORD_BITS;
   localparam int FB        = FRAC_BITS;
   localparam int SB        = CB - 1;
   localparam int STEP_BITS = FB + 8;
   localparam int IN_W      = ((10*CB + FB + 4 + 7) / 8) * 8;
   localparam int OUT_W     = ((3*CB + 5 + 7) / 8) * 8;
   localparam int DIR_BITS  = CB + 8;
   localparam int OFS_BITS  = CB + 2;
   localparam int VPROD     = CB + STEP_BITS + 1;
   localparam int DIV_LAT   = CB + 2;
   localparam int LO_BITS   = DIR_BITS / 2;
   localparam int HI_BITS   = DIR_BITS - LO_BITS;
   localparam int PHI_BITS  = CB + HI_BITS;
   localparam int PLO_BITS  = CB + LO_BITS + 1;
   localparam int PROD_BITS = CB + DIR_BITS;
   localparam int EXT_BITS  = PROD_BITS + 1;

   // field offsets in req_tdata
   localparam int O_MX = 0;
   localparam int O_MY = CB;
   localparam int O_MW = 2*CB;
   localparam int O_MH = 2*CB + SB;
   localparam int O_TX = 2*CB + 2*SB;
   localparam int O_TY = 3*CB + 2*SB;
   localparam int O_TW = 4*CB + 2*SB;
   localparam int O_TH = 4*CB + 3*SB;
   localparam int O_VX = 4*CB + 4*SB;
   localparam int O_VY = 5*CB + 4*SB;
   localparam int O_ST = 6*CB + 4*SB;

   localparam logic signed [EXT_BITS-1:0] XMAX = signed'({{(EXT_BITS-CB+1){1'b0}},
                                                          {(CB-1){1'b1}}});
   localparam logic signed [EXT_BITS-1:0] XMIN = -XMAX - 1;
   localparam logic signed [CB-1:0]       T_ONE = signed'(CB'(1) << FB);

   // sideband that rides beside the dividers
   typedef struct packed {
      logic                       valid;
      logic                       rej;
      logic signed [DIR_BITS-1:0] dx;
      logic signed [DIR_BITS-1:0] dy;
      logic signed [CB-1:0]       mx;
      logic signed [CB-1:0]       my;
   } side_type;

   sbc_pkg::pipe_ctl_type ctl;
   logic adv;

   // request fields
   logic signed [CB-1:0]    mx, my, tx, ty, vx, vy;
   logic [SB-1:0]           mw, mh, tw, th;
   logic [STEP_BITS-1:0]    st;
   logic signed [VPROD-1:0] pvx, pvy;

   // stage a: direction and slab offsets
   logic                       a_valid_ff;
   logic                       a_vzero_ff, a_vzero_in;
   logic signed [DIR_BITS-1:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic signed [OFS_BITS-1:0] a_onx_ff, a_onx_in, a_ofx_ff, a_ofx_in;
   logic signed [OFS_BITS-1:0] a_ony_ff, a_ony_in, a_ofy_ff, a_ofy_in;
   logic signed [CB-1:0]       a_mx_ff, a_my_ff;

   // divider span
   side_type             dly_ff [0:DIV_LAT-1];
   side_type             dly_in;
   logic signed [CB-1:0] tnx, tfx, tny, tfy;
   side_type             side;

   // stage c: slab intervals combined
   logic signed [CB-1:0]       snx, sfx, sny, sfy, thit, tfar;
   logic                       c_valid_ff, c_rej_ff, c_rej_in;
   logic signed [CB-1:0]       c_thit_ff;
   logic [1:0]                 c_nx_ff, c_nx_in, c_ny_ff, c_ny_in;
   logic signed [DIR_BITS-1:0] c_dx_ff, c_dy_ff;
   logic signed [CB-1:0]       c_mx_ff, c_my_ff;

   // stage d: partial products of entry time and direction
   logic                       d_valid_ff, d_rej_ff;
   logic signed [CB-1:0]       d_thit_ff, d_mx_ff, d_my_ff;
   logic [1:0]                 d_nx_ff, d_ny_ff;
   logic signed [PHI_BITS-1:0] d_phx_ff, d_phx_in, d_phy_ff, d_phy_in;
   logic signed [PLO_BITS-1:0] d_plx_ff, d_plx_in, d_ply_ff, d_ply_in;

   // stage e: full products
   logic                        e_valid_ff, e_rej_ff;
   logic signed [CB-1:0]        e_thit_ff, e_mx_ff, e_my_ff;
   logic [1:0]                  e_nx_ff, e_ny_ff;
   logic signed [PROD_BITS-1:0] e_px_ff, e_px_in, e_py_ff, e_py_in;

   // stage f: corner moved to contact
   logic                       f_valid_ff, f_rej_ff;
   logic signed [CB-1:0]       f_thit_ff;
   logic [1:0]                 f_nx_ff, f_ny_ff;
   logic signed [EXT_BITS-1:0] f_sx_ff, f_sx_in, f_sy_ff, f_sy_in;

   // stage g: response register
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff, rsp_data_in;
   logic signed [CB-1:0] cx, cy;
   logic                 hit;

   // whole pipeline moves when the response register can take a new transaction
   assign adv        = ~rsp_valid_ff | rsp_tready;
   assign ctl.adv    = adv;
   assign req_tready = adv;

   assign mx = signed'(req_tdata[O_MX +: CB]);
   assign my = signed'(req_tdata[O_MY +: CB]);
   assign mw = req_tdata[O_MW +: SB];
   assign mh = req_tdata[O_MH +: SB];
   assign tx = signed'(req_tdata[O_TX +: CB]);
   assign ty = signed'(req_tdata[O_TY +: CB]);
   assign tw = req_tdata[O_TW +: SB];
   assign th = req_tdata[O_TH +: SB];
   assign vx = signed'(req_tdata[O_VX +: CB]);
   assign vy = signed'(req_tdata[O_VY +: CB]);
   assign st = req_tdata[O_ST +: STEP_BITS];

   // direction d = floor(vel * step / 2^frac), exact
   assign pvx = VPROD'(vx) * signed'(VPROD'(st));
   assign pvy = VPROD'(vy) * signed'(VPROD'(st));

   always_comb begin
      a_vzero_in = (vx == '0) && (vy == '0);
      a_dx_in    = DIR_BITS'(pvx >>> FB);
      a_dy_in    = DIR_BITS'(pvy >>> FB);
      // target grown by the mover size, offsets relative to the mover corner
      a_onx_in   = OFS_BITS'(tx) - signed'(OFS_BITS'(mw)) - OFS_BITS'(mx);
      a_ofx_in   = OFS_BITS'(tx) + signed'(OFS_BITS'(tw)) - OFS_BITS'(mx);
      a_ony_in   = OFS_BITS'(ty) - signed'(OFS_BITS'(mh)) - OFS_BITS'(my);
      a_ofy_in   = OFS_BITS'(ty) + signed'(OFS_BITS'(th)) - OFS_BITS'(my);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_vzero_ff <= a_vzero_in;
         a_dx_ff    <= a_dx_in;
         a_dy_ff    <= a_dy_in;
         a_onx_ff   <= a_onx_in;
         a_ofx_ff   <= a_ofx_in;
         a_ony_ff   <= a_ony_in;
         a_ofy_ff   <= a_ofy_in;
         a_mx_ff    <= mx;
         a_my_ff    <= my;
      end
   end

   // four slab times: near and far per axis
   sbc_div #(.NUM_W(OFS_BITS), .DEN_W(DIR_BITS), .QUO_W(CB), .FRAC_W(FB)) u_div_nx (
      .clock(clock), .ctl(ctl), .num(a_onx_ff), .den(a_dx_ff), .quo(tnx));
   sbc_div #(.NUM_W(OFS_BITS), .DEN_W(DIR_BITS), .QUO_W(CB), .FRAC_W(FB)) u_div_fx (
      .clock(clock), .ctl(ctl), .num(a_ofx_ff), .den(a_dx_ff), .quo(tfx));
   sbc_div #(.NUM_W(OFS_BITS), .DEN_W(DIR_BITS), .QUO_W(CB), .FRAC_W(FB)) u_div_ny (
      .clock(clock), .ctl(ctl), .num(a_ony_ff), .den(a_dy_ff), .quo(tny));
   sbc_div #(.NUM_W(OFS_BITS), .DEN_W(DIR_BITS), .QUO_W(CB), .FRAC_W(FB)) u_div_fy (
      .clock(clock), .ctl(ctl), .num(a_ofy_ff), .den(a_dy_ff), .quo(tfy));

   // zero velocity and the undefined zero-over-zero ratio reject here
   always_comb begin
      dly_in.valid = a_valid_ff;
      dly_in.rej   = a_vzero_ff ||
                     ((a_dx_ff == '0) && ((a_onx_ff == '0) || (a_ofx_ff == '0))) ||
                     ((a_dy_ff == '0) && ((a_ony_ff == '0) || (a_ofy_ff == '0)));
      dly_in.dx    = a_dx_ff;
      dly_in.dy    = a_dy_ff;
      dly_in.mx    = a_mx_ff;
      dly_in.my    = a_my_ff;
   end

   // sideband delay line; only the valid bits are cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            dly_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         dly_ff[0] <= dly_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign side = dly_ff[DIV_LAT-1];

   // order each slab, test for separation, pick entry and exit
   always_comb begin
      snx  = (tnx > tfx) ? tfx : tnx;
      sfx  = (tnx > tfx) ? tnx : tfx;
      sny  = (tny > tfy) ? tfy : tny;
      sfy  = (tny > tfy) ? tny : tfy;
      thit = (snx > sny) ? snx : sny;
      tfar = (sfx < sfy) ? sfx : sfy;
      c_rej_in = side.rej || (snx > sfy) || (sny > sfx) || (tfar < 0);
      c_nx_in  = sbc_pkg::NORM_ZERO;
      c_ny_in  = sbc_pkg::NORM_ZERO;
      // equal near times leave the diagonal normal at zero
      if (snx > sny) begin
         c_nx_in = (side.dx < 0) ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
      end else if (snx < sny) begin
         c_ny_in = (side.dy < 0) ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= side.valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_rej_ff  <= c_rej_in;
         c_thit_ff <= thit;
         c_nx_ff   <= c_nx_in;
         c_ny_ff   <= c_ny_in;
         c_dx_ff   <= side.dx;
         c_dy_ff   <= side.dy;
         c_mx_ff   <= side.mx;
         c_my_ff   <= side.my;
      end
   end

   // entry time times direction, split into a signed high and unsigned low half
   assign d_phx_in = PHI_BITS'(c_thit_ff) *
                     PHI_BITS'(signed'(c_dx_ff[DIR_BITS-1:LO_BITS]));
   assign d_phy_in = PHI_BITS'(c_thit_ff) *
                     PHI_BITS'(signed'(c_dy_ff[DIR_BITS-1:LO_BITS]));
   assign d_plx_in = PLO_BITS'(c_thit_ff) * signed'(PLO_BITS'(c_dx_ff[LO_BITS-1:0]));
   assign d_ply_in = PLO_BITS'(c_thit_ff) * signed'(PLO_BITS'(c_dy_ff[LO_BITS-1:0]));

   always_ff @(posedge clock) begin
      if (adv) begin
         d_rej_ff  <= c_rej_ff;
         d_thit_ff <= c_thit_ff;
         d_nx_ff   <= c_nx_ff;
         d_ny_ff   <= c_ny_ff;
         d_mx_ff   <= c_mx_ff;
         d_my_ff   <= c_my_ff;
         d_phx_ff  <= d_phx_in;
         d_phy_ff  <= d_phy_in;
         d_plx_ff  <= d_plx_in;
         d_ply_ff  <= d_ply_in;
      end
   end

   assign e_px_in = (PROD_BITS'(d_phx_ff) <<< LO_BITS) + PROD_BITS'(d_plx_ff);
   assign e_py_in = (PROD_BITS'(d_phy_ff) <<< LO_BITS) + PROD_BITS'(d_ply_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         e_rej_ff  <= d_rej_ff;
         e_thit_ff <= d_thit_ff;
         e_nx_ff   <= d_nx_ff;
         e_ny_ff   <= d_ny_ff;
         e_mx_ff   <= d_mx_ff;
         e_my_ff   <= d_my_ff;
         e_px_ff   <= e_px_in;
         e_py_ff   <= e_py_in;
      end
   end

   // floor of the scaled product added to the corner
   assign f_sx_in = EXT_BITS'(e_mx_ff) + EXT_BITS'(e_px_ff >>> FB);
   assign f_sy_in = EXT_BITS'(e_my_ff) + EXT_BITS'(e_py_ff >>> FB);

   always_ff @(posedge clock) begin
      if (adv) begin
         f_rej_ff  <= e_rej_ff;
         f_thit_ff <= e_thit_ff;
         f_nx_ff   <= e_nx_ff;
         f_ny_ff   <= e_ny_ff;
         f_sx_ff   <= f_sx_in;
         f_sy_ff   <= f_sy_in;
      end
   end

   // clamp the contact point and build the response; a reject sends all zeros
   always_comb begin
      cx = (f_sx_ff > XMAX) ? CB'(XMAX) : (f_sx_ff < XMIN) ? CB'(XMIN) : CB'(f_sx_ff);
      cy = (f_sy_ff > XMAX) ? CB'(XMAX) : (f_sy_ff < XMIN) ? CB'(XMIN) : CB'(f_sy_ff);
      hit = (f_thit_ff >= 0) && (f_thit_ff < T_ONE);
      if (f_rej_ff) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = OUT_W'({f_ny_ff, f_nx_ff, cy, cx, f_thit_ff, hit});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a reported hit always carries an entry time inside [0,1)
   a_hit_window : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |->
         (!rsp_tdata[CB] && (rsp_tdata[CB:1] < CB'(T_ONE))))
      else $error("hit reported with entry time outside the unit window");

   // the contact normal never points along both axes
   a_normal_axis : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[3*CB+2:3*CB+1] == sbc_pkg::NORM_ZERO) ||
                      (rsp_tdata[3*CB+4:3*CB+3] == sbc_pkg::NORM_ZERO)))
      else $error("normal set on both axes");

   // an accepted transaction enters the first stage
   a_enter : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> a_valid_ff)
      else $error("accepted transaction lost at pipeline entry");

   // a stall freezes the stages behind the dividers
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(c_valid_ff) && $stable(f_valid_ff) && $stable(c_thit_ff)))
      else $error("pipeline moved during a stall");

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the swept box collision pipeline
`timescale 1ns / 100ps

module tb_top;

   localparam int REQ_W = ((10*32+16+4+7)/8)*8;
   localparam int RSP_W = ((3*32+5+7)/8)*8;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;
   localparam longint ONE = 64'sd65536;

   typedef struct {
      logic signed [31:0] mover_x, mover_y;
      logic [30:0] mover_w, mover_h;
      logic signed [31:0] target_x, target_y;
      logic [30:0] target_w, target_h;
      logic signed [31:0] vel_x, vel_y;
      logic [23:0] step_time;
   } query_type;

   typedef struct {
      logic hit;
      logic [31:0] contact_time, contact_x, contact_y;
      logic [1:0] normal_x, normal_y;
   } contact_type;

   // floor(a*b / 2^16), magnitude capped at 2^62
   function automatic longint fix_mul_floor(longint a, longint b);
      logic signed [127:0] pa, pb, p;
      pa = a;
      pb = b;
      p = (pa * pb) >>> 16;
      if (p > (128'sd1 <<< 62)) p = 128'sd1 <<< 62;
      if (p < -(128'sd1 <<< 62)) p = -(128'sd1 <<< 62);
      return longint'(p);
   endfunction

   // offset*2^16/d, truncated toward zero, saturated to 32 bits signed
   function automatic longint slab_entry(longint num, longint den);
      logic neg;
      logic [127:0] n, d, q, lim;
      if (den == 0) return (num > 0) ? Q_MAX : Q_MIN;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      lim = neg ? 128'd2147483648 : 128'd2147483647;
      q = (n << 16) / d;
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_q(longint v);
      return (v > Q_MAX) ? Q_MAX : (v < Q_MIN) ? Q_MIN : v;
   endfunction

   function automatic contact_type predict_contact(query_type r);
      contact_type c;
      longint mx, my, mw, mh, tx, ty, tw, th, vx, vy, st;
      longint dx, dy, onx, ofx, ony, ofy, tnx, tfx, tny, tfy, tmp, t_hit, t_far;
      c = '{default: '0};
      mx = $signed(r.mover_x);  my = $signed(r.mover_y);
      tx = $signed(r.target_x); ty = $signed(r.target_y);
      vx = $signed(r.vel_x);    vy = $signed(r.vel_y);
      mw = r.mover_w;  mh = r.mover_h;
      tw = r.target_w; th = r.target_h;
      st = r.step_time;
      if (vx == 0 && vy == 0) return c;
      dx = fix_mul_floor(vx, st);
      dy = fix_mul_floor(vy, st);
      onx = tx - mw - mx;  ofx = tx + tw - mx;
      ony = ty - mh - my;  ofy = ty + th - my;
      // zero direction with a zero offset has no defined ratio
      if ((dx == 0 && (onx == 0 || ofx == 0)) || (dy == 0 && (ony == 0 || ofy == 0)))
         return c;
      tnx = slab_entry(onx, dx); tfx = slab_entry(ofx, dx);
      tny = slab_entry(ony, dy); tfy = slab_entry(ofy, dy);
      if (tnx > tfx) begin tmp = tnx; tnx = tfx; tfx = tmp; end
      if (tny > tfy) begin tmp = tny; tny = tfy; tfy = tmp; end
      if (tnx > tfy || tny > tfx) return c;
      t_hit = (tnx > tny) ? tnx : tny;
      t_far = (tfx < tfy) ? tfx : tfy;
      if (t_far < 0) return c;
      c.hit = (t_hit >= 0 && t_hit < ONE);
      c.contact_time = t_hit[31:0];
      c.contact_x = 32'(clamp_q(mx + fix_mul_floor(t_hit, dx)));
      c.contact_y = 32'(clamp_q(my + fix_mul_floor(t_hit, dy)));
      if (tnx > tny) c.normal_x = (dx < 0) ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
      else if (tnx < tny) c.normal_y = (dy < 0) ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
      return c;
   endfunction

   class contact_scoreboard;
      contact_type pending[$];
      int errors = 0;
      int checked = 0;
      int hits = 0;

      function void note_query(query_type r);
         pending.push_back(predict_contact(r));
      endfunction

      function void check_reply(contact_type got);
         contact_type want;
         bit bad;
         bad = 1'b0;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing expected: %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.hit) hits++;
         if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            bad = 1'b1;
         end
         if (got.contact_time !== want.contact_time) begin
            $display("%0t: contact_time expected %h actual %h", $time,
                     want.contact_time, got.contact_time);
            bad = 1'b1;
         end
         if (got.contact_x !== want.contact_x) begin
            $display("%0t: contact_x expected %h actual %h", $time,
                     want.contact_x, got.contact_x);
            bad = 1'b1;
         end
         if (got.contact_y !== want.contact_y) begin
            $display("%0t: contact_y expected %h actual %h", $time,
                     want.contact_y, got.contact_y);
            bad = 1'b1;
         end
         if (got.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %b actual %b", $time,
                     want.normal_x, got.normal_x);
            bad = 1'b1;
         end
         if (got.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %b actual %b", $time,
                     want.normal_y, got.normal_y);
            bad = 1'b1;
         end
         if (bad) errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   contact_scoreboard sb = new();
   int sent = 0;
   bit no_gaps = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   swept_box_collision uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic query_type unpack_query(logic [REQ_W-1:0] d);
      query_type r;
      r.mover_x  = d[31:0];    r.mover_y  = d[63:32];
      r.mover_w  = d[94:64];   r.mover_h  = d[125:95];
      r.target_x = d[157:126]; r.target_y = d[189:158];
      r.target_w = d[220:190]; r.target_h = d[251:221];
      r.vel_x    = d[283:252]; r.vel_y    = d[315:284];
      r.step_time = d[339:316];
      return r;
   endfunction

   // transaction monitor for both channels
   always @(posedge clock) begin
      contact_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_query(unpack_query(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tdata[0];
            got.contact_time = rsp_tdata[32:1];
            got.contact_x = rsp_tdata[64:33];
            got.contact_y = rsp_tdata[96:65];
            got.normal_x = rsp_tdata[98:97];
            got.normal_y = rsp_tdata[100:99];
            sb.check_reply(got);
         end
      end
   end

   // receiver: random stalls, a quiet stretch, and one long hold-off to back up the pipe
   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 1000 && cyc < 1400) rsp_tready <= 1'b0;
         else if (cyc >= 2000 && cyc < 2800) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(99) >= 33);
      end
   end

   // one transaction on the request channel, sometimes after a random gap unless no_gaps is set
   task automatic send_query(query_type r);
      if (!no_gaps && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, r.step_time, r.vel_y, r.vel_x, r.target_h, r.target_w,
                    r.target_y, r.target_x, r.mover_h, r.mover_w, r.mover_y, r.mover_x};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   function automatic query_type scene(longint mx, longint my, longint mw, longint mh,
                                       longint tx, longint ty, longint tw, longint th,
                                       longint vx, longint vy, longint st);
      query_type r;
      r.mover_x = 32'(mx);  r.mover_y = 32'(my);
      r.mover_w = 31'(mw);  r.mover_h = 31'(mh);
      r.target_x = 32'(tx); r.target_y = 32'(ty);
      r.target_w = 31'(tw); r.target_h = 31'(th);
      r.vel_x = 32'(vx);    r.vel_y = 32'(vy);
      r.step_time = 24'(st);
      return r;
   endfunction

   // mover and target within a span of 100 or 2000 units of the origin, so most queries reach the slab compare
   function automatic query_type near_scene();
      query_type r;
      int span;
      span = $urandom_range(3) == 0 ? 2000 : 100;
      r.mover_x  = $urandom_range(2*span*65536) - span*65536;
      r.mover_y  = $urandom_range(2*span*65536) - span*65536;
      r.mover_w  = 31'($urandom_range(20*65536));
      r.mover_h  = 31'($urandom_range(20*65536));
      r.target_x = $urandom_range(2*span*65536) - span*65536;
      r.target_y = $urandom_range(2*span*65536) - span*65536;
      r.target_w = 31'($urandom_range(40*65536));
      r.target_h = 31'($urandom_range(40*65536));
      r.vel_x    = $urandom_range(4*span*65536) - 2*span*65536;
      r.vel_y    = $urandom_range(4*span*65536) - 2*span*65536;
      r.step_time = 24'($urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF) :
                                                  $urandom_range(2*65536));
      // aim vel_x at the target now and then, and sometimes zero one axis for axis-aligned motion
      if ($urandom_range(3) == 0) r.vel_x = $signed(r.target_x) - $signed(r.mover_x);
      if ($urandom_range(7) == 0) r.vel_x = 0;
      else if ($urandom_range(7) == 0) r.vel_y = 0;
      if ($urandom_range(15) == 0) begin
         r.mover_w = 0;
         r.target_w = 0;
      end
      return r;
   endfunction

   function automatic query_type noise_scene();
      query_type r;
      r.mover_x = $urandom;       r.mover_y = $urandom;
      r.mover_w = 31'($urandom);  r.mover_h = 31'($urandom);
      r.target_x = $urandom;      r.target_y = $urandom;
      r.target_w = 31'($urandom); r.target_h = 31'($urandom);
      r.vel_x = $urandom;         r.vel_y = $urandom;
      r.step_time = 24'($urandom);
      return r;
   endfunction

   initial begin
      query_type dq[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero velocity
      dq.push_back(scene(0, 0, 65536, 65536, 5*65536, 0, 65536, 65536, 0, 0, 65536));
      // straight right hit, left-facing normal
      dq.push_back(scene(0, 0, 65536, 65536, 5*65536, 0, 65536, 65536, 10*65536, 0, 65536));
      // moving left, right-facing normal
      dq.push_back(scene(10*65536, 0, 65536, 65536, 0, 0, 65536, 65536,
                         -20*65536, 0, 65536));
      // moving down and up
      dq.push_back(scene(0, 0, 65536, 65536, 0, 6*65536, 65536, 65536, 0, 10*65536, 65536));
      dq.push_back(scene(0, 6*65536, 65536, 65536, 0, 0, 65536, 65536,
                         0, -10*65536, 65536));
      // diagonal corner entry gives a zero normal
      dq.push_back(scene(0, 0, 65536, 65536, 4*65536, 4*65536, 65536, 65536,
                         8*65536, 8*65536, 65536));
      // zero direction with a zero offset on a boundary
      dq.push_back(scene(0, 0, 65536, 65536, 65536, 5*65536, 65536, 65536,
                         0, 10*65536, 65536));
      // zero direction inside and outside the slab
      dq.push_back(scene(0, 0, 65536, 65536, 0, 5*65536, 4*65536, 65536,
                         0, 10*65536, 65536));
      dq.push_back(scene(0, 0, 65536, 65536, 9*65536, 5*65536, 65536, 65536,
                         0, 10*65536, 65536));
      // separated slabs
      dq.push_back(scene(0, 0, 65536, 65536, 5*65536, 50*65536, 65536, 65536,
                         10*65536, 10*65536, 65536));
      // target behind
      dq.push_back(scene(20*65536, 0, 65536, 65536, 0, 0, 65536, 65536,
                         10*65536, 0, 65536));
      // out of window: too far to reach this step
      dq.push_back(scene(0, 0, 65536, 65536, 50*65536, 0, 65536, 65536, 10*65536, 0, 65536));
      // already overlapping, entry time negative
      dq.push_back(scene(0, 0, 4*65536, 4*65536, 65536, 65536, 65536, 65536,
                         65536, 0, 65536));
      // zero step time with nonzero velocity
      dq.push_back(scene(0, 0, 65536, 65536, 5*65536, 0, 65536, 65536, 65536, 65536, 0));
      // field extremes
      dq.push_back(scene(Q_MIN, Q_MIN, 0, 0, Q_MAX, Q_MAX, 31'h7FFFFFFF, 31'h7FFFFFFF,
                         Q_MAX, Q_MAX, 24'hFFFFFF));
      dq.push_back(scene(Q_MAX, Q_MAX, 31'h7FFFFFFF, 31'h7FFFFFFF, Q_MIN, Q_MIN, 0, 0,
                         Q_MIN, Q_MIN, 24'hFFFFFF));
      dq.push_back(scene(Q_MIN, 0, 31'h7FFFFFFF, 1, Q_MAX, 0, 31'h7FFFFFFF, 1,
                         1, Q_MIN, 1));
      dq.push_back(scene(-1, -1, 1, 1, 1, 1, 1, 1, -1, 1, 24'hFFFFFF));
      dq.push_back(scene(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 24'hFFFFFF));
      foreach (dq[i]) send_query(dq[i]);

      for (int n = 0; n < 1600; n++) begin
         no_gaps = (n >= 700 && n < 1000);
         if ($urandom_range(99) < 80) send_query(near_scene());
         else send_query(noise_scene());
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d queries, %0d responses checked, %0d of them hits", sent,
               sb.checked, sb.hits);
      $display("directed cases: zero velocity, undefined ratio, separated, behind, diagonal");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #(20 * 200000);
      $display("timeout after %0d queries sent", sent);
      $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
sv/sbc_pkg.sv
sv/sbc_div.sv
sv/swept_box_collision.sv
sim/tb_top.sv
